// ===== hdl/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg: shared definitions of the indexed list engine
// Field widths, stream packing, operation codes and command kinds.
// ----------------------------------------------------------------------------
package ile_pkg;

	localparam int CAPACITY_DEF = 256;

	localparam int FUNC_W = 3;
	localparam int POS_W  = 10;
	localparam int VAL_W  = 32;
	localparam int LEN_W  = 9;

	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 3;
	localparam int S_VAL_LSB = POS_W;

	localparam int M_TDATA_W = 48;
	localparam int M_HIT_BIT = VAL_W;
	localparam int M_ACC_BIT = VAL_W + 1;
	localparam int M_LEN_LSB = VAL_W + 2;
	localparam int M_PAD_W   = M_TDATA_W - (VAL_W + 2 + LEN_W);

	localparam logic [VAL_W-1:0] MINUS_ONE = '1;
	localparam logic [POS_W-1:0] POS_HEAD  = '1;

	typedef enum logic [FUNC_W-1:0] {
		FN_GET      = 3'd0,
		FN_ADD_HEAD = 3'd1,
		FN_ADD_TAIL = 3'd2,
		FN_ADD_AT   = 3'd3,
		FN_DELETE   = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_READ   = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_kind_t;

	// packed command: kind, accepted, position, count before, count after, value
	function automatic int cmd_width(input int capacity);
		return 2 + 1 + $clog2(capacity) + 2 * $clog2(capacity + 1) + VAL_W;
	endfunction

endpackage

// ===== hdl/ile_front.sv =====
// ----------------------------------------------------------------------------
// ile_front: request decoder
// Accepts request words, tracks the list length and turns each request into
// a command that is already resolved to read, insert, delete or no-op.
// ----------------------------------------------------------------------------
module ile_front #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int CMDW = ile_pkg::cmd_width(CAPACITY)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ile_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [ile_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output logic [CMDW-1:0]                cmd_data
);

	localparam int CMPW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

	typedef struct packed {
		ile_pkg::cmd_kind_t          kind;
		logic                        accepted;
		logic [AW-1:0]               pos;
		logic [CW-1:0]               count;
		logic [CW-1:0]               new_len;
		logic [ile_pkg::VAL_W-1:0]   value;
	} cmd_t;

	logic [CW-1:0]               count_q;
	logic [ile_pkg::POS_W-1:0]   pos_raw;
	logic [CMPW-1:0]             pos_x;
	logic [CMPW-1:0]             count_x;
	logic                        pos_nonneg;
	logic                        full;
	logic                        in_range;
	cmd_t                        cmd;

	assign pos_raw    = s_tdata[ile_pkg::POS_W-1:0];
	assign pos_x      = CMPW'(pos_raw);
	assign count_x    = CMPW'(count_q);
	assign pos_nonneg = !pos_raw[ile_pkg::POS_W-1];
	assign full       = (count_q == CW'(CAPACITY));
	assign in_range   = pos_nonneg && (pos_x < count_x);

	always_comb begin
		cmd.kind     = ile_pkg::CMD_NONE;
		cmd.pos      = AW'(pos_x);
		cmd.count    = count_q;
		cmd.value    = s_tdata[ile_pkg::S_VAL_LSB +: ile_pkg::VAL_W];
		case (ile_pkg::func_t'(s_tuser)) 
			ile_pkg::FN_GET: begin
				if (in_range) cmd.kind = ile_pkg::CMD_READ;
			end
			ile_pkg::FN_ADD_HEAD: begin
				if (!full) cmd.kind = ile_pkg::CMD_INSERT;
				cmd.pos = '0;
			end
			ile_pkg::FN_ADD_TAIL: begin
				if (!full) cmd.kind = ile_pkg::CMD_INSERT;
				cmd.pos = AW'(count_q);
			end
			ile_pkg::FN_ADD_AT: begin
				if (pos_raw == ile_pkg::POS_HEAD) begin
					if (!full) cmd.kind = ile_pkg::CMD_INSERT;
					cmd.pos = '0;
				end else if (pos_nonneg && (pos_x <= count_x) && !full) begin
					cmd.kind = ile_pkg::CMD_INSERT;
				end
			end
			ile_pkg::FN_DELETE: begin
				if (in_range) cmd.kind = ile_pkg::CMD_DELETE;
			end
			default: begin
				cmd.kind = ile_pkg::CMD_NONE;
			end
		endcase
		cmd.accepted = (cmd.kind == ile_pkg::CMD_INSERT) || (cmd.kind == ile_pkg::CMD_DELETE);
		case (cmd.kind)
			ile_pkg::CMD_INSERT: cmd.new_len = count_q + 1'b1;
			ile_pkg::CMD_DELETE: cmd.new_len = count_q - 1'b1;
			default:             cmd.new_len = count_q;
		endcase
	end

	assign s_tready  = cmd_ready;
	assign cmd_valid = s_tvalid;
	assign cmd_data  = cmd;

	// advance the length as soon as the word is taken; the back end follows in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (s_tvalid && cmd_ready) begin
			count_q <= cmd.new_len;
		end
	end

endmodule

// ===== hdl/ile_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ile_cmd_fifo: two-entry command queue
// Decouples the request decoder from the list sequencer.
// ----------------------------------------------------------------------------
module ile_cmd_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic [W-1:0] entry_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = entry_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/ile_back.sv =====
// ----------------------------------------------------------------------------
// ile_back: list sequencer
// Carries out commands on the element memory, shifting one element a cycle,
// and places each result word in the output register.
// ----------------------------------------------------------------------------
module ile_back #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int CMDW = ile_pkg::cmd_width(CAPACITY)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  logic [CMDW-1:0]                cmd_data,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ile_pkg::M_TDATA_W-1:0]  m_tdata
);

	localparam int LW = ile_pkg::LEN_W;
	localparam int VW = ile_pkg::VAL_W;

	typedef struct packed {
		ile_pkg::cmd_kind_t  kind;
		logic                accepted;
		logic [AW-1:0]       pos;
		logic [CW-1:0]       count;
		logic [CW-1:0]       new_len;
		logic [VW-1:0]       value;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_PUT,
		ST_DEL,
		ST_EMIT
	} state_t;

	state_t                        state_q;
	cmd_t                          cmd_in;
	cmd_t                          cmd_q;
	logic [CW-1:0]                 ptr_q;
	logic [CW-1:0]                 ptr_inc;
	logic [CW-1:0]                 ptr_dec;
	logic                          pend_q;
	logic [AW-1:0]                 pend_addr_q;
	logic                          ins_more;
	logic                          del_more;
	logic                          take;
	logic                          out_free;
	logic                          hit;
	logic [VW-1:0]                 read_value;

	logic [VW-1:0]                 mem [CAPACITY];
	logic [VW-1:0]                 rd_data_q;
	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [VW-1:0]                 wr_data;

	logic                          m_valid_q;
	logic [ile_pkg::M_TDATA_W-1:0] m_data_q;

	assign cmd_in    = cmd_t'(cmd_data);
	assign cmd_ready = (state_q == ST_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign ptr_inc   = ptr_q + 1'b1;
	assign ptr_dec   = ptr_q - 1'b1;
	assign ins_more  = ptr_q > CW'(cmd_q.pos);
	assign del_more  = ptr_inc < cmd_q.count;
	assign out_free  = !m_valid_q || m_tready;
	assign hit       = (cmd_q.kind == ile_pkg::CMD_READ);
	assign read_value = hit ? rd_data_q : ile_pkg::MINUS_ONE;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cmd_in.pos;
		case (state_q)
			ST_IDLE: begin
				rd_en = take && (cmd_in.kind == ile_pkg::CMD_READ);
			end
			ST_INS: begin
				rd_en   = ins_more;
				rd_addr = AW'(ptr_dec);
			end
			ST_DEL: begin
				rd_en   = del_more;
				rd_addr = AW'(ptr_inc);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// the trailing move of a shift has priority; the insert value lands after it
	assign wr_en   = pend_q || (state_q == ST_PUT);
	assign wr_addr = pend_q ? pend_addr_q : cmd_q.pos;
	assign wr_data = pend_q ? rd_data_q : cmd_q.value;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			pend_addr_q <= '0;
			m_valid_q   <= 1'b0;
			m_data_q    <= '0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					pend_q <= 1'b0;
					if (take) begin
						cmd_q <= cmd_in;
						case (cmd_in.kind)
							ile_pkg::CMD_INSERT: begin
								ptr_q   <= cmd_in.count;
								state_q <= ST_INS;
							end
							ile_pkg::CMD_DELETE: begin
								ptr_q   <= CW'(cmd_in.pos);
								state_q <= ST_DEL;
							end
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_INS: begin
					if (ins_more) begin
						pend_q      <= 1'b1;
						pend_addr_q <= AW'(ptr_q);
						ptr_q       <= ptr_dec;
					end else begin
						pend_q  <= 1'b0;
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					state_q <= ST_EMIT;
				end
				ST_DEL: begin
					if (del_more) begin
						pend_q      <= 1'b1;
						pend_addr_q <= AW'(ptr_q);
						ptr_q       <= ptr_inc;
					end else begin
						pend_q  <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_data_q  <= {{ile_pkg::M_PAD_W{1'b0}}, LW'(cmd_q.new_len),
						              cmd_q.accepted, hit, read_value};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== hdl/indexed_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine: ordered list of signed 32-bit values
// Request stream in, one result word out per request.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser carries the operation code, s_tdata
// the position and the value. Each request gives exactly one result word on the
// m_ stream with the read value, hit and accepted flags and the new length.
// A get reads the element at position p; an insert shifts the elements from p on
// up by one and then writes the value at p; a delete shifts those above p down by
// one; a refused or unused operation only emits its result. The element memory
// has one read and one write port, so a shift moves one element a cycle. The
// decoder resolves each request against its own copy of the length; up to two
// commands queue behind it, so requests are taken during a shift until it fills.
// The result sits in an output register; while the receiver stalls it holds,
// the sequencer finishes the next command and then waits, and once the queue
// fills s_tready drops.
// Reset empties the list at once; the memory needs no clearing pass since only
// entries below the length are ever read.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// position [9:0], item_value [41:10], zero fill above
	input  logic [ile_pkg::S_TDATA_W-1:0]  s_tdata,
	// func [2:0]
	input  logic [ile_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// read_value [31:0], hit [32], accepted [33], list_length [42:34], zero fill
	output logic [ile_pkg::M_TDATA_W-1:0]  m_tdata
);

	localparam int CMDW = ile_pkg::cmd_width(CAPACITY);

	logic            fr_valid;
	logic            fr_ready;
	logic [CMDW-1:0] fr_data;
	logic            bk_valid;
	logic            bk_ready;
	logic [CMDW-1:0] bk_data;

	// decode and length tracking
	ile_front #(.CAPACITY(CAPACITY)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd_data  (fr_data)
	);

	// hold up to two resolved commands between the two halves
	ile_cmd_fifo #(.W(CMDW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   (fr_data),
		.out_valid (bk_valid),
		.out_ready (bk_ready),
		.out_data  (bk_data)
	);

	// memory sequencer and result register
	ile_back #(.CAPACITY(CAPACITY)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.cmd_data  (bk_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== hdl/ile_checker.sv =====
// ----------------------------------------------------------------------------
// ile_checker: port-level checks of the indexed list engine
// Watches the request and result streams and the reported length.
// ----------------------------------------------------------------------------
module ile_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ile_pkg::M_TDATA_W-1:0]  m_tdata
);

	localparam int LW = ile_pkg::LEN_W;

	logic          in_hs;
	logic          out_hs;
	logic [3:0]    inflight_q;
	logic [LW-1:0] last_len_q;
	logic [LW-1:0] len;
	logic          hit;
	logic          acc;

	assign in_hs  = s_tvalid && s_tready;
	assign out_hs = m_tvalid && m_tready;
	assign len    = m_tdata[ile_pkg::M_LEN_LSB +: LW];
	assign hit    = m_tdata[ile_pkg::M_HIT_BIT];
	assign acc    = m_tdata[ile_pkg::M_ACC_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			last_len_q <= '0;
		end else begin
			case ({in_hs, out_hs})
				2'b10:   inflight_q <= inflight_q + 4'd1;
				2'b01:   inflight_q <= inflight_q - 4'd1;
				default: inflight_q <= inflight_q;
			endcase
			if (out_hs) last_len_q <= len;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs |-> inflight_q != 4'd0)
		else $error("result word without a pending request");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs |-> (!acc && len == last_len_q) ||
		           (acc && (len == last_len_q + 1'b1 || len == last_len_q - 1'b1)))
		else $error("length moved inconsistently with accepted flag");

	a_hit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs && hit |-> !acc && len != '0 && last_len_q == len)
		else $error("hit on an empty list or with a list change");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
